// ===== sv/sfr_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the serial frame receiver.
`timescale 1ns / 1ps

package sfr_pkg;

  localparam int SFR_MAX_PAYLOAD = 56;
  localparam int SFR_LEN_W       = 6;
  localparam int SFR_QUEUE_DEPTH = 2;

  localparam logic [15:0] SFR_CRC_INIT = 16'hFFFF;
  localparam logic [15:0] SFR_CRC_POLY = 16'hA001;

  localparam logic [7:0] SFR_FIRST_HDR_RESET  = 8'hAA;
  localparam logic [7:0] SFR_SECOND_HDR_RESET = 8'h55;

  // Register indexes on the configuration port
  localparam logic REG_FIRST_HDR  = 1'b0;
  localparam logic REG_SECOND_HDR = 1'b1;

  typedef logic [SFR_LEN_W-1:0] len_t;

  // Descriptor of one completed frame, handed from parser to drain
  typedef struct packed {
    logic       ok;
    logic [7:0] cmd;
    len_t       len;
  } job_t;

  // Payload store write port
  typedef struct packed {
    logic       en;
    len_t       addr;
    logic [7:0] data;
  } mem_wr_t;

  // Reflected CRC-16 update over one byte, eight shift steps
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ SFR_CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/serial_frame_receiver_crc16.sv =====
// Top level of the serial frame receiver with CRC-16 check and configuration port.
`timescale 1ns / 1ps

// Received bytes are taken one per cycle while a frame is being parsed: the
// parser hunts for the two header bytes, reads the command and length, writes
// the payload into a store of MAX_PAYLOAD bytes and checks the CRC-16 (Modbus)
// that follows, low byte first. Each completed frame leaves a descriptor in a
// two-entry queue. The drain turns it into result items: one per payload byte,
// each going through a store read and then the output register, or a single
// item for an empty frame or a CRC error. While a previous frame is still
// draining, payload bytes of the next frame are stalled so that the store is
// not overwritten, and the second CRC byte waits while both queue entries are
// occupied; all other bytes are taken at once. The store is not cleared after
// reset and needs no clearing pass. Header values are set through the
// configuration port at byte addresses 0 and 4.

module serial_frame_receiver_crc16 import sfr_pkg::*; #(
  parameter int MAX_PAYLOAD = SFR_MAX_PAYLOAD
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_frame_ok,
  output logic [7:0]  out_command_code,
  output logic [5:0]  out_payload_length,
  output logic        out_has_data,
  output logic [7:0]  out_data_byte,
  output logic [5:0]  out_byte_index,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] first_hdr_r;
  logic [7:0] second_hdr_r;
  logic       cfg_wr;

  logic    q_push;
  logic    q_pop;
  logic    q_not_empty;
  logic    q_full;
  job_t    q_job;
  job_t    q_head;
  mem_wr_t mem_wr;
  logic    back_busy;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_SECOND_HDR) ? {24'd0, second_hdr_r} : {24'd0, first_hdr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_hdr_r  <= SFR_FIRST_HDR_RESET;
      second_hdr_r <= SFR_SECOND_HDR_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_FIRST_HDR) begin
        first_hdr_r <= pwdata[7:0];
      end else begin
        second_hdr_r <= pwdata[7:0];
      end
    end
  end

  sfr_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .first_hdr  (first_hdr_r),
    .second_hdr (second_hdr_r),
    .back_busy  (back_busy),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (q_job),
    .mem_wr     (mem_wr)
  );

  sfr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_job),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .full      (q_full),
    .head      (q_head)
  );

  sfr_back #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .mem_wr             (mem_wr),
    .q_not_empty        (q_not_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .busy               (back_busy),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frame_ok       (out_frame_ok),
    .out_command_code   (out_command_code),
    .out_payload_length (out_payload_length),
    .out_has_data       (out_has_data),
    .out_data_byte      (out_data_byte),
    .out_byte_index     (out_byte_index),
    .out_last           (out_last)
  );

endmodule

// ===== sv/sfr_front.sv =====
// Frame parser: hunts for the header, stores the payload and checks the CRC.
`timescale 1ns / 1ps

module sfr_front import sfr_pkg::*; #(
  parameter int MAX_PAYLOAD = SFR_MAX_PAYLOAD
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic [7:0] first_hdr,
  input  logic [7:0] second_hdr,
  input  logic       back_busy,
  input  logic       q_full,
  output logic       q_push,
  output job_t       q_job,
  output mem_wr_t    mem_wr
);

  typedef enum logic [6:0] {
    F_IDLE  = 7'b0000001,
    F_HDR1  = 7'b0000010,
    F_HDR2  = 7'b0000100,
    F_CMD   = 7'b0001000,
    F_DATA  = 7'b0010000,
    F_CRCLO = 7'b0100000,
    F_CRCHI = 7'b1000000
  } phase_t;

  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  len_t        len_r, len_nxt;
  len_t        count_r, count_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic        accept;
  logic [15:0] crc_upd;
  len_t        count_inc;

  // The payload store must not be overwritten while an earlier frame drains.
  assign in_stall = ((phase_r == F_DATA) && back_busy) || ((phase_r == F_CRCHI) && q_full);
  assign accept   = in_valid && !in_stall;
  assign crc_upd  = crc16_feed((phase_r == F_IDLE) ? SFR_CRC_INIT : crc_r, in_rx_byte);
  assign count_inc = count_r + len_t'(1);

  always_comb begin
    phase_nxt  = phase_r;
    cmd_nxt    = cmd_r;
    len_nxt    = len_r;
    count_nxt  = count_r;
    crc_nxt    = crc_r;
    crc_lo_nxt = crc_lo_r;
    q_push     = 1'b0;
    q_job.ok   = ({in_rx_byte, crc_lo_r} == crc_r);
    q_job.cmd  = cmd_r;
    q_job.len  = len_r;
    mem_wr.en   = 1'b0;
    mem_wr.addr = count_r;
    mem_wr.data = in_rx_byte;
    if (accept) begin
      case (phase_r)
        F_IDLE: begin
          if (in_rx_byte == first_hdr) begin
            crc_nxt   = crc_upd;
            count_nxt = '0;
            phase_nxt = F_HDR1;
          end
        end
        F_HDR1: begin
          if (in_rx_byte == second_hdr) begin
            crc_nxt   = crc_upd;
            phase_nxt = F_HDR2;
          end else begin
            phase_nxt = F_IDLE;
          end
        end
        F_HDR2: begin
          cmd_nxt   = in_rx_byte;
          crc_nxt   = crc_upd;
          phase_nxt = F_CMD;
        end
        F_CMD: begin
          if (in_rx_byte == 8'd0) begin
            len_nxt   = '0;
            crc_nxt   = crc_upd;
            phase_nxt = F_CRCLO;
          end else if (in_rx_byte <= MAX_LEN) begin
            len_nxt   = in_rx_byte[SFR_LEN_W-1:0];
            count_nxt = '0;
            crc_nxt   = crc_upd;
            phase_nxt = F_DATA;
          end else begin
            phase_nxt = F_IDLE;
          end
        end
        F_DATA: begin
          mem_wr.en = 1'b1;
          count_nxt = count_inc;
          crc_nxt   = crc_upd;
          if (count_inc >= len_r) begin
            phase_nxt = F_CRCLO;
          end
        end
        F_CRCLO: begin
          crc_lo_nxt = in_rx_byte;
          phase_nxt  = F_CRCHI;
        end
        F_CRCHI: begin
          q_push    = 1'b1;
          phase_nxt = F_IDLE;
        end
        default: begin
          phase_nxt = F_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= F_IDLE;
      cmd_r    <= '0;
      len_r    <= '0;
      count_r  <= '0;
      crc_r    <= SFR_CRC_INIT;
      crc_lo_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      cmd_r    <= cmd_nxt;
      len_r    <= len_nxt;
      count_r  <= count_nxt;
      crc_r    <= crc_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

endmodule

// ===== sv/sfr_queue.sv =====
// Short queue of completed frame descriptors between parser and drain.
`timescale 1ns / 1ps

module sfr_queue import sfr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic not_empty,
  output logic full,
  output job_t head
);

  localparam int PTR_W = (SFR_QUEUE_DEPTH > 1) ? $clog2(SFR_QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(SFR_QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(SFR_QUEUE_DEPTH - 1);

  job_t             slot_r [SFR_QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == CNT_W'(SFR_QUEUE_DEPTH));
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== sv/sfr_back.sv =====
// Result drain: holds the payload store and turns each frame descriptor into result items.
`timescale 1ns / 1ps

module sfr_back import sfr_pkg::*; #(
  parameter int MAX_PAYLOAD = SFR_MAX_PAYLOAD
) (
  input  logic       clk,
  input  logic       rst_n,
  input  mem_wr_t    mem_wr,
  input  logic       q_not_empty,
  input  job_t       q_head,
  output logic       q_pop,
  output logic       busy,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_frame_ok,
  output logic [7:0] out_command_code,
  output logic [5:0] out_payload_length,
  output logic       out_has_data,
  output logic [7:0] out_data_byte,
  output logic [5:0] out_byte_index,
  output logic       out_last
);

  localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_READ = 3'b010,
    B_LOAD = 3'b100
  } bstate_t;

  logic [7:0] mem [MAX_PAYLOAD];

  bstate_t    state_r, state_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  len_t       len_r, len_nxt;
  len_t       idx_r, idx_nxt;
  logic [7:0] rd_data_r;

  logic       valid_r, valid_nxt;
  logic       ok_r, ok_nxt;
  logic [7:0] ocmd_r, ocmd_nxt;
  len_t       olen_r, olen_nxt;
  logic       has_r, has_nxt;
  logic [7:0] data_r, data_nxt;
  len_t       oidx_r, oidx_nxt;
  logic       last_r, last_nxt;

  logic out_free;
  logic is_data;
  logic idx_last;

  assign out_free = !valid_r || !out_stall;
  assign is_data  = q_head.ok && (q_head.len != '0);
  assign idx_last = ((idx_r + len_t'(1)) == len_r);
  assign q_pop    = (state_r == B_IDLE) && q_not_empty && (is_data || out_free);
  assign busy     = q_not_empty || (state_r != B_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    valid_nxt = valid_r && out_stall;
    ok_nxt    = ok_r;
    ocmd_nxt  = ocmd_r;
    olen_nxt  = olen_r;
    has_nxt   = has_r;
    data_nxt  = data_r;
    oidx_nxt  = oidx_r;
    last_nxt  = last_r;
    case (state_r)
      B_IDLE: begin
        if (q_pop) begin
          if (is_data) begin
            cmd_nxt   = q_head.cmd;
            len_nxt   = q_head.len;
            idx_nxt   = '0;
            state_nxt = B_READ;
          end else begin
            // Error or empty frame: a single result without payload
            valid_nxt = 1'b1;
            ok_nxt    = q_head.ok;
            ocmd_nxt  = q_head.cmd;
            olen_nxt  = q_head.len;
            has_nxt   = 1'b0;
            data_nxt  = '0;
            oidx_nxt  = '0;
            last_nxt  = 1'b1;
          end
        end
      end
      B_READ: begin
        state_nxt = B_LOAD;
      end
      B_LOAD: begin
        if (out_free) begin
          valid_nxt = 1'b1;
          ok_nxt    = 1'b1;
          ocmd_nxt  = cmd_r;
          olen_nxt  = len_r;
          has_nxt   = 1'b1;
          data_nxt  = rd_data_r;
          oidx_nxt  = idx_r;
          last_nxt  = idx_last;
          if (idx_last) begin
            state_nxt = B_IDLE;
          end else begin
            idx_nxt   = idx_r + len_t'(1);
            state_nxt = B_READ;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    len_r  <= len_nxt;
    idx_r  <= idx_nxt;
    ok_r   <= ok_nxt;
    ocmd_r <= ocmd_nxt;
    olen_r <= olen_nxt;
    has_r  <= has_nxt;
    data_r <= data_nxt;
    oidx_r <= oidx_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      mem[mem_wr.addr[ADDR_W-1:0]] <= mem_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_READ) begin
      rd_data_r <= mem[idx_r[ADDR_W-1:0]];
    end
  end

  assign out_valid          = valid_r;
  assign out_frame_ok       = ok_r;
  assign out_command_code   = ocmd_r;
  assign out_payload_length = olen_r;
  assign out_has_data       = has_r;
  assign out_data_byte      = data_r;
  assign out_byte_index     = oidx_r;
  assign out_last           = last_r;

endmodule
